// ----- rtl/core/tldl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tldl_pkg: shared types and constants for the tridiagonal LDL^T factor
// Transaction payload structs, value widths and fixed-point limits.
// ----------------------------------------------------------------------------
package tldl_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int POS_WIDTH   = 17;
    localparam int PROD_WIDTH  = 2 * VALUE_WIDTH;

    localparam logic [POS_WIDTH-1:0] MAX_ROWS = POS_WIDTH'(65536);

    typedef logic signed [VALUE_WIDTH-1:0] t_value;
    typedef logic        [POS_WIDTH-1:0]   t_pos;

    localparam t_value VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam t_value VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    typedef struct packed {
        t_value     diag_in;
        t_value     offdiag_in;
        logic       last_row;
    } t_in_item;

    typedef struct packed {
        t_value     pivot_out;
        t_value     mult_out;
        t_pos       fail_position;
        logic       last_out;
    } t_out_item;

endpackage

// ----- rtl/core/tldl_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tldl_divider: radix-2 restoring divider for the row multiplier
// Forms (num * 2^16) / den, den > 0, truncated toward zero and saturated.
// ----------------------------------------------------------------------------
module tldl_divider (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  tldl_pkg::t_value i_num,
    input  tldl_pkg::t_value i_den,
    output logic            o_done,
    output tldl_pkg::t_value o_quot
);
    import tldl_pkg::*;

    localparam int CNT_WIDTH = $clog2(VALUE_WIDTH);

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_RUN  = 3'b010,
        D_FIX  = 3'b100
    } t_div_state;

    t_div_state                 r_state, n_state;
    logic                       r_neg;
    logic                       r_ovf;
    logic [VALUE_WIDTH-1:0]     r_den;
    logic [VALUE_WIDTH-1:0]     r_rem;
    logic [VALUE_WIDTH-1:0]     r_shift;
    logic [CNT_WIDTH-1:0]       r_cnt;

    logic [VALUE_WIDTH-1:0]     w_mag;
    logic                       w_ovf;
    logic [VALUE_WIDTH:0]       w_trial;
    logic                       w_ge;
    logic [VALUE_WIDTH:0]       w_sub;

    assign w_mag   = i_num[VALUE_WIDTH-1] ? (~i_num + 1'b1) : i_num;
    assign w_ovf   = {FRAC_BITS'(0), w_mag} >= {i_den, FRAC_BITS'(0)};
    assign w_trial = {r_rem, r_shift[VALUE_WIDTH-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_sub   = w_trial - {1'b0, r_den};

    always_comb begin
        n_state = r_state;
        case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_state = w_ovf ? D_FIX : D_RUN;
                end
            end
            D_RUN: begin
                if (r_cnt == CNT_WIDTH'(VALUE_WIDTH - 1)) begin
                    n_state = D_FIX;
                end
            end
            D_FIX:   n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == D_IDLE && i_start) begin
            r_neg   <= i_num[VALUE_WIDTH-1];
            r_ovf   <= w_ovf;
            r_den   <= i_den;
            r_rem   <= VALUE_WIDTH'(w_mag[VALUE_WIDTH-1:FRAC_BITS]);
            r_shift <= {w_mag[FRAC_BITS-1:0], FRAC_BITS'(0)};
            r_cnt   <= '0;
        end else if (r_state == D_RUN) begin
            r_rem   <= w_ge ? w_sub[VALUE_WIDTH-1:0] : w_trial[VALUE_WIDTH-1:0];
            r_shift <= {r_shift[VALUE_WIDTH-2:0], w_ge};
            r_cnt   <= r_cnt + 1'b1;
        end
    end

    always_comb begin
        if (r_ovf) begin
            o_quot = r_neg ? VAL_MIN : VAL_MAX;
        end else if (!r_neg) begin
            o_quot = r_shift[VALUE_WIDTH-1] ? VAL_MAX : r_shift;
        end else if (r_shift > VAL_MIN) begin
            o_quot = VAL_MIN;
        end else begin
            o_quot = ~r_shift + 1'b1;
        end
    end

    assign o_done = (r_state == D_FIX);

endmodule

// ----- rtl/core/tridiagonal_ldlt_factor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tridiagonal_ldlt_factor: streaming L*D*L^T factor of a tridiagonal matrix
// One transaction per matrix row in, one result transaction per row out.
// ----------------------------------------------------------------------------
// Input channel i_in_valid / o_in_stall carries one row (d_i, e_i, last flag);
// output channel o_out_valid / i_out_stall carries the pivot, the multiplier,
// the first failing row (0 while all pivots are positive) and the last flag.
// A row runs through a multiply step, a pivot step and, when a multiplier
// is needed, a radix-2 divider: 32 quotient steps and a fix-up step.
// When the quotient saturates before the loop, the quotient steps are skipped;
// o_in_stall is high while a row is in work, and a new row is accepted only
// after the previous one has left the output state.
// The output register holds a result until taken; a new row is accepted
// meanwhile, but its result waits while the receiver stalls.
// The state after the last row of a matrix returns to the reset state.
// Reset (i_rst_n low, synchronous) clears the sequencer, the output valid
// and the carried row state.
// ----------------------------------------------------------------------------
module tridiagonal_ldlt_factor (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  tldl_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output tldl_pkg::t_out_item  o_out_data
);
    import tldl_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_PIV  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state                 r_state;
    t_in_item               r_item;
    t_pos                   r_pos;
    logic signed [PROD_WIDTH-1:0] r_prod;
    t_value                 r_pivot;
    t_value                 r_mult;
    t_value                 r_prev_mult;
    t_value                 r_prev_off;
    t_pos                   r_row_count;
    logic                   r_failed;
    t_pos                   r_failed_row;
    logic                   r_out_valid;
    t_out_item              r_out;

    logic signed [PROD_WIDTH-1:0] w_prod;
    logic signed [PROD_WIDTH-1:0] w_diff;
    t_value                 w_piv;
    logic                   w_div_start;
    logic                   w_div_done;
    t_value                 w_quot;
    logic                   w_out_free;
    t_value                 w_pass_mult;

    assign w_prod = r_prev_mult * r_prev_off;
    assign w_diff = $signed({{(PROD_WIDTH-VALUE_WIDTH){r_item.diag_in[VALUE_WIDTH-1]}},
                             r_item.diag_in}) - (r_prod >>> FRAC_BITS);

    always_comb begin
        if (w_diff > $signed({{(PROD_WIDTH-VALUE_WIDTH){1'b0}}, VAL_MAX})) begin
            w_piv = VAL_MAX;
        end else if (w_diff < $signed({{(PROD_WIDTH-VALUE_WIDTH){1'b1}}, VAL_MIN})) begin
            w_piv = VAL_MIN;
        end else begin
            w_piv = w_diff[VALUE_WIDTH-1:0];
        end
    end

    assign w_pass_mult = r_item.last_row ? '0 : r_item.offdiag_in;
    assign w_div_start = (r_state == S_PIV) && !r_failed && !r_item.last_row &&
                         !w_piv[VALUE_WIDTH-1] && (w_piv != '0);
    assign w_out_free  = !r_out_valid || !i_out_stall;

    tldl_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_item.offdiag_in),
        .i_den   (w_piv),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_prev_mult  <= '0;
            r_prev_off   <= '0;
            r_row_count  <= '0;
            r_failed     <= 1'b0;
            r_failed_row <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_PIV;
                end
                S_PIV: begin
                    if (r_failed) begin
                        r_state <= S_OUT;
                    end else if (w_piv[VALUE_WIDTH-1] || w_piv == '0) begin
                        r_failed     <= 1'b1;
                        r_failed_row <= r_pos;
                        r_state      <= S_OUT;
                    end else if (r_item.last_row) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_prev_mult <= w_quot;
                        r_prev_off  <= r_item.offdiag_in;
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state     <= S_IDLE;
                        if (r_item.last_row) begin
                            r_prev_mult  <= '0;
                            r_prev_off   <= '0;
                            r_row_count  <= '0;
                            r_failed     <= 1'b0;
                            r_failed_row <= '0;
                        end else begin
                            r_row_count <= r_pos;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_item <= i_in_data;
                    r_pos  <= (r_row_count >= MAX_ROWS) ? MAX_ROWS : r_row_count + 1'b1;
                end
            end
            S_MUL: begin
                r_prod <= w_prod;
            end
            S_PIV: begin
                if (r_failed) begin
                    r_pivot <= r_item.diag_in;
                    r_mult  <= w_pass_mult;
                end else if (w_piv[VALUE_WIDTH-1] || w_piv == '0) begin
                    r_pivot <= w_piv;
                    r_mult  <= w_pass_mult;
                end else begin
                    r_pivot <= w_piv;
                    r_mult  <= '0;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    r_mult <= w_quot;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_out.pivot_out     <= r_pivot;
                    r_out.mult_out      <= r_mult;
                    r_out.fail_position <= r_failed ? r_failed_row : '0;
                    r_out.last_out      <= r_item.last_row;
                end
            end
            default: begin
                r_pivot <= r_pivot;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- verif/tb_tridiagonal_ldlt_factor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tridiagonal_ldlt_factor: self-checking bench for the streaming LDL^T factor
// Streams tridiagonal matrices row by row through the block. It starts with a
// short table of hand-picked rows (saturation, zero and negative pivots,
// pass-through after a failure) and follows with random matrices: mostly
// diagonally dominant ones, some broken mid-matrix, some pure noise.
// Every result is compared with the table's expected value or with a fixed-point
// model of the factorization. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_tridiagonal_ldlt_factor;

    import tldl_pkg::*;

    localparam longint VMAX       = longint'(VAL_MAX);
    localparam longint VMIN       = longint'(VAL_MIN);
    localparam int     ROW_LIMIT  = int'(MAX_ROWS);
    localparam int     RAND_ROWS  = 1250;

    typedef struct {
        t_in_item   row;
        logic       typed;
        t_out_item  want;
    } t_row_case;

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_stall;
    t_in_item   i_in_data   = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_item  o_out_data;

    // factorization state carried between rows
    longint     carry_mult;
    longint     carry_offdiag;
    int         rows_taken;
    logic       pivot_failed;
    int         fail_row;

    t_out_item  factored_rows[$];
    t_row_case  row_cases[$];

    logic       no_gaps;
    int         stall_left;
    int         mismatch_count;
    int         rows_sent;
    int         rows_checked;
    int         matrices_done;
    int         matrices_failed;

    tridiagonal_ldlt_factor dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #(100_000_000);
        $display("FAILURE");
        $finish;
    end

    function automatic longint clamp_value(input longint v);
        if (v > VMAX) begin
            return VMAX;
        end
        if (v < VMIN) begin
            return VMIN;
        end
        return v;
    endfunction

    function automatic t_out_item factor_row(input t_in_item r);
        t_out_item res;
        longint    d;
        longint    e;
        longint    piv;
        longint    quo;
        int        pos;
        d   = $signed(r.diag_in);
        e   = $signed(r.offdiag_in);
        pos = (rows_taken >= ROW_LIMIT) ? ROW_LIMIT : rows_taken + 1;
        if (pivot_failed) begin
            piv = d;
            quo = r.last_row ? 0 : e;
        end else begin
            piv = clamp_value(d - ((carry_mult * carry_offdiag) >>> FRAC_BITS));
            if (piv <= 0) begin
                pivot_failed = 1'b1;
                fail_row     = pos;
                quo          = r.last_row ? 0 : e;
            end else if (r.last_row) begin
                quo = 0;
            end else begin
                quo           = clamp_value((e <<< FRAC_BITS) / piv);
                carry_mult    = quo;
                carry_offdiag = e;
            end
        end
        res.pivot_out     = piv[VALUE_WIDTH-1:0];
        res.mult_out      = quo[VALUE_WIDTH-1:0];
        res.fail_position = pivot_failed ? fail_row[POS_WIDTH-1:0] : '0;
        res.last_out      = r.last_row;
        if (r.last_row) begin
            carry_mult    = 0;
            carry_offdiag = 0;
            rows_taken    = 0;
            pivot_failed  = 1'b0;
            fail_row      = 0;
        end else begin
            rows_taken = pos;
        end
        return res;
    endfunction

    function automatic int idle_len();
        int roll;
        if (no_gaps) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    task automatic add_row_case(input t_value d, input t_value e, input logic lr,
                                input logic typed, input t_value p, input t_value m,
                                input t_pos pos);
        t_row_case c;
        c.row.diag_in         = d;
        c.row.offdiag_in      = e;
        c.row.last_row        = lr;
        c.typed               = typed;
        c.want.pivot_out      = p;
        c.want.mult_out       = m;
        c.want.fail_position  = pos;
        c.want.last_out       = lr;
        row_cases.push_back(c);
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_row(input t_in_item r, input logic typed, input t_out_item want);
        int        gap;
        t_out_item model_res;
        gap = idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (o_in_stall);
        model_res = factor_row(r);
        factored_rows.push_back(typed ? want : model_res);
        rows_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        while (factored_rows.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            i_out_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0) begin
                stall_left = idle_len();
            end
        end else begin
            i_out_stall <= 1'b1;
            stall_left--;
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        logic      bad;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (factored_rows.size() == 0) begin
                mismatch_count++;
                $error("unexpected result transaction: %h", o_out_data);
            end else begin
                want = factored_rows.pop_front();
                bad  = (want !== o_out_data);
                if (bad) begin
                    if (want.pivot_out !== o_out_data.pivot_out)
                        $error("pivot_out: expected %h, got %h",
                               want.pivot_out, o_out_data.pivot_out);
                    if (want.mult_out !== o_out_data.mult_out)
                        $error("mult_out: expected %h, got %h",
                               want.mult_out, o_out_data.mult_out);
                    if (want.fail_position !== o_out_data.fail_position)
                        $error("fail_position: expected %0d, got %0d",
                               want.fail_position, o_out_data.fail_position);
                    if (want.last_out !== o_out_data.last_out)
                        $error("last_out: expected %b, got %b",
                               want.last_out, o_out_data.last_out);
                    mismatch_count++;
                end
                rows_checked++;
                if (want.last_out) begin
                    matrices_done++;
                    if (want.fail_position != '0) begin
                        matrices_failed++;
                    end
                end
            end
        end
    end

    initial begin
        t_in_item  r;
        int        n;
        int        style;
        int        k;
        int        bad_at;
        int        i;
        int        rand_rows;
        logic      paused;
        longint    mag;
        longint    prev_mag;
        longint    dv;
        longint    ev;

        carry_mult      = 0;
        carry_offdiag   = 0;
        rows_taken      = 0;
        pivot_failed    = 1'b0;
        fail_row        = 0;
        no_gaps         = 1'b0;
        stall_left      = 0;
        mismatch_count  = 0;
        rows_sent       = 0;
        rows_checked    = 0;
        matrices_done   = 0;
        matrices_failed = 0;
        rand_rows       = 0;
        paused          = 1'b0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // d, e, last, typed, pivot, mult, fail position
        add_row_case(32'h0001_0000, 32'hFFFF_FFFF, 1, 1, 32'h0001_0000, 32'h0, 17'd0);
        add_row_case(32'h0000_0000, 32'h0000_0000, 1, 1, 32'h0000_0000, 32'h0, 17'd1);
        add_row_case(VAL_MAX,       VAL_MAX,       0, 1, VAL_MAX, 32'h0001_0000, 17'd0);
        add_row_case(VAL_MAX,       VAL_MIN,       0, 1, 32'h0, VAL_MIN, 17'd2);
        add_row_case(VAL_MIN,       32'h1234_5678, 0, 1, VAL_MIN, 32'h1234_5678, 17'd2);
        add_row_case(32'h0000_0005, 32'h0000_0007, 1, 1, 32'h5, 32'h0, 17'd2);
        add_row_case(32'h0000_0001, VAL_MAX,       0, 1, 32'h1, VAL_MAX, 17'd0);
        add_row_case(VAL_MAX,       32'h0000_0000, 1, 1, VAL_MIN, 32'h0, 17'd2);
        add_row_case(32'h0000_0001, VAL_MIN,       0, 1, 32'h1, VAL_MIN, 17'd0);
        add_row_case(32'h0001_0000, 32'hFFFF_FFFF, 0, 1, VAL_MIN, 32'hFFFF_FFFF, 17'd2);
        add_row_case(32'h0000_0000, 32'h0000_0000, 1, 1, 32'h0, 32'h0, 17'd2);
        add_row_case(32'h0002_0000, 32'hFFFF_0000, 0, 1, 32'h0002_0000, 32'hFFFF_8000, 17'd0);
        add_row_case(32'h0002_0000, 32'hFFFF_0000, 0, 0, 32'h0, 32'h0, 17'd0);
        add_row_case(32'h0003_0000, 32'h0001_0000, 0, 0, 32'h0, 32'h0, 17'd0);
        add_row_case(32'h0001_0000, 32'h0000_0000, 1, 0, 32'h0, 32'h0, 17'd0);
        add_row_case(32'hFFFF_0000, 32'h0000_0003, 0, 1, 32'hFFFF_0000, 32'h3, 17'd1);
        add_row_case(32'h0000_0009, 32'h0000_0009, 1, 1, 32'h9, 32'h0, 17'd1);

        foreach (row_cases[j]) begin
            send_row(row_cases[j].row, row_cases[j].typed, row_cases[j].want);
        end
        i_in_valid <= 1'b0;
        drain_results();

        while (rand_rows < RAND_ROWS) begin
            if (!paused && rand_rows >= RAND_ROWS / 2) begin
                paused = 1'b1;
                i_in_valid <= 1'b0;
                drain_results();
            end
            no_gaps  = ($urandom_range(0, 5) == 0);
            n        = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                   : $urandom_range(1, 12);
            style    = $urandom_range(0, 99);
            k        = $urandom_range(4, 29);
            bad_at   = $urandom_range(1, n);
            prev_mag = 0;
            for (i = 1; i <= n; i++) begin
                r.last_row = (i == n);
                if (style >= 85) begin
                    r.diag_in    = $urandom;
                    r.offdiag_in = $urandom;
                end else begin
                    mag = $urandom_range(0, (1 << k) - 1);
                    ev  = $urandom_range(0, 1) ? -mag : mag;
                    dv  = prev_mag + mag + $urandom_range(1, 1 << k);
                    if (style >= 70 && i == bad_at) begin
                        case ($urandom_range(0, 2))
                            0: dv = 0;
                            1: dv = -dv;
                            default: dv = prev_mag >> 2;
                        endcase
                    end
                    r.diag_in    = dv[VALUE_WIDTH-1:0];
                    r.offdiag_in = r.last_row ? t_value'($urandom) : ev[VALUE_WIDTH-1:0];
                    prev_mag     = mag;
                end
                send_row(r, 1'b0, '0);
                rand_rows++;
            end
        end
        no_gaps = 1'b0;

        i_in_valid <= 1'b0;
        while (factored_rows.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("Checked %0d of %0d rows over %0d matrices, %0d with a failed pivot.",
                 rows_checked, rows_sent, matrices_done, matrices_failed);
        $display("Rows came from a directed table and random matrices under random gaps.");
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/tldl_pkg.sv
rtl/core/tldl_divider.sv
rtl/core/tridiagonal_ldlt_factor.sv
verif/tb_tridiagonal_ldlt_factor.sv
